// ===== hw/rtl/gfdc_pkg.sv =====
package gfdc_pkg;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_GAIN        = 3'd0;
  localparam logic [2:0] REG_FORCE_LIMIT = 3'd1;
  localparam logic [2:0] REG_LIN_COMPL   = 3'd2;
  localparam logic [2:0] REG_ROOT_COEF   = 3'd3;
  localparam logic [2:0] REG_LIN_MODE    = 3'd4;
  localparam logic [2:0] REG_START_RUN   = 3'd5;

  localparam logic [23:0] GAIN_RST        = 24'd65536;
  localparam logic [22:0] FORCE_LIMIT_RST = 23'd1310720;
  localparam logic [31:0] LIN_COMPL_RST   = 32'd3355443;
  localparam logic [31:0] ROOT_COEF_RST   = 32'd3300114;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_START   = 2'd2,
    KIND_STOP    = 2'd3
  } kind_t;

  // microprogram
  typedef logic [3:0] step_t;

  localparam step_t STEP_MEAS = 4'd0;
  localparam step_t STEP_ZERO = 4'd15;

  // square root: two result bits per iteration, sixteen iterations
  localparam logic [3:0] SQ_LAST = 4'd15;

  typedef enum logic [1:0] {
    MUL_FM  = 2'd0,
    MUL_FT  = 2'd1,
    MUL_ELO = 2'd2,
    MUL_EHI = 2'd3
  } mul_sel_t;

  typedef enum logic [1:0] {
    C_NEXT    = 2'd0,
    C_ROOT    = 2'd1,
    C_SQ_MORE = 2'd2,
    C_ALWAYS  = 2'd3
  } cond_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     prod_en;
    logic     d_lin_en;
    logic     sq_load;
    logic     sq_step;
    logic     dm_en;
    logic     diff_en;
    logic     acc_lo;
    logic     acc_hi;
    logic     emit_calc;
    logic     emit_zero;
    cond_t    cond;
    step_t    target;
    logic     last;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t w;
    w = '0;
    case (step)
      4'd0: begin
        w.mul_sel = MUL_FM;
        w.prod_en = 1'b1;
        w.cond    = C_ROOT;
        w.target  = 4'd2;
      end
      4'd1: begin
        w.d_lin_en = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = 4'd4;
      end
      4'd2: begin
        w.sq_load = 1'b1;
      end
      4'd3: begin
        w.sq_step = 1'b1;
        w.cond    = C_SQ_MORE;
        w.target  = 4'd3;
      end
      4'd4: begin
        w.dm_en   = 1'b1;
        w.mul_sel = MUL_FT;
        w.prod_en = 1'b1;
        w.cond    = C_ROOT;
        w.target  = 4'd6;
      end
      4'd5: begin
        w.d_lin_en = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = 4'd8;
      end
      4'd6: begin
        w.sq_load = 1'b1;
      end
      4'd7: begin
        w.sq_step = 1'b1;
        w.cond    = C_SQ_MORE;
        w.target  = 4'd7;
      end
      4'd8: begin
        w.diff_en = 1'b1;
      end
      4'd9: begin
        w.mul_sel = MUL_ELO;
        w.prod_en = 1'b1;
      end
      4'd10: begin
        w.mul_sel = MUL_EHI;
        w.prod_en = 1'b1;
        w.acc_lo  = 1'b1;
      end
      4'd11: begin
        w.acc_hi = 1'b1;
      end
      4'd12: begin
        w.emit_calc = 1'b1;
        w.last      = 1'b1;
      end
      STEP_ZERO: begin
        w.emit_zero = 1'b1;
        w.last      = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/gfdc_seq.sv =====
module gfdc_seq import gfdc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  step_t      start_step,
  input  logic       linear_mode,
  input  logic       sq_more,
  input  logic       out_free,
  output ctrl_word_t ctrl,
  output logic       ready
);

  logic       active;
  step_t      step;
  ctrl_word_t word;
  logic       hold;
  logic       exec;
  logic       jump;

  always_comb begin
    word = ucode_rom(step);
    // an emitting step waits for room in the output register
    hold = (word.emit_calc | word.emit_zero) & ~out_free;
    exec = active & ~hold;
    ctrl = exec ? word : '0;
    ready = ~active | (exec & word.last);
    case (word.cond)
      C_NEXT:    jump = 1'b0;
      C_ROOT:    jump = ~linear_mode;
      C_SQ_MORE: jump = sq_more;
      C_ALWAYS:  jump = 1'b1;
      default:   jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= STEP_MEAS;
    end else if (start) begin
      active <= 1'b1;
      step   <= start_step;
    end else if (exec) begin
      if (word.last) begin
        active <= 1'b0;
      end else if (jump) begin
        step <= word.target;
      end else begin
        step <= step + 4'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/gfdc_dp.sv =====
module gfdc_dp import gfdc_pkg::*; (
  input  logic        clk,
  input  ctrl_word_t  ctrl,
  input  logic [23:0] f_mag,
  input  logic [22:0] target_force,
  input  logic [23:0] gain,
  input  logic [31:0] linear_compliance,
  input  logic [31:0] root_coefficient,
  input  logic        linear_mode,
  output logic        sq_more,
  output logic [31:0] velocity_calc,
  output logic        clipped_calc
);

  logic [31:0] coef;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] prod;
  logic [55:0] lin_round;
  logic [39:0] d_lin;
  logic [39:0] d_sel;
  logic [39:0] dm;
  logic [39:0] e;
  logic        neg;
  logic [63:0] acc;

  // square root unit
  logic [63:0] rad;
  logic [33:0] rem;
  logic [31:0] root;
  logic [3:0]  sq_cnt;
  logic [35:0] r1;
  logic [35:0] t1;
  logic        ge1;
  logic [33:0] rem1;
  logic [31:0] root1;
  logic [35:0] r2;
  logic [35:0] t2;
  logic        ge2;
  logic [33:0] rem2;
  logic [31:0] root2;

  // saturation
  logic [64:0] rsum;
  logic [40:0] mag;

  always_comb begin
    coef = linear_mode ? linear_compliance : root_coefficient;
    case (ctrl.mul_sel)
      MUL_FM: begin
        mul_a = coef;
        mul_b = f_mag;
      end
      MUL_FT: begin
        mul_a = coef;
        mul_b = {1'b0, target_force};
      end
      MUL_ELO: begin
        mul_a = e[31:0];
        mul_b = gain;
      end
      MUL_EHI: begin
        mul_a = {24'd0, e[39:32]};
        mul_b = gain;
      end
      default: begin
        mul_a = coef;
        mul_b = f_mag;
      end
    endcase
  end

  assign lin_round = prod + 56'h8000;
  assign d_sel     = linear_mode ? d_lin : {8'd0, root};

  // two digits of the restoring root per cycle
  always_comb begin
    r1    = {rem, rad[63:62]};
    t1    = {2'b00, root, 2'b01};
    ge1   = (r1 >= t1);
    rem1  = ge1 ? 34'(r1 - t1) : r1[33:0];
    root1 = {root[30:0], ge1};
    r2    = {rem1, rad[61:60]};
    t2    = {2'b00, root1, 2'b01};
    ge2   = (r2 >= t2);
    rem2  = ge2 ? 34'(r2 - t2) : r2[33:0];
    root2 = {root1[30:0], ge2};
  end

  assign sq_more = (sq_cnt != SQ_LAST);

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod <= {24'd0, mul_a} * {32'd0, mul_b};
    end
    if (ctrl.d_lin_en) begin
      d_lin <= lin_round[55:16];
    end
    if (ctrl.sq_load) begin
      rad    <= {prod, 8'd0};
      rem    <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end else if (ctrl.sq_step) begin
      rad    <= {rad[59:0], 4'd0};
      rem    <= rem2;
      root   <= root2;
      sq_cnt <= sq_cnt + 4'd1;
    end
    if (ctrl.dm_en) begin
      dm <= d_sel;
    end
    if (ctrl.diff_en) begin
      neg <= (dm < d_sel);
      e   <= (dm < d_sel) ? (d_sel - dm) : (dm - d_sel);
    end
    if (ctrl.acc_lo) begin
      acc <= {8'd0, prod};
    end else if (ctrl.acc_hi) begin
      acc <= acc + {prod[31:0], 32'd0};
    end
  end

  always_comb begin
    rsum = {1'b0, acc} + 65'h800000;
    mag  = rsum[64:24];
    if (neg) begin
      if (mag > 41'h080000000) begin
        velocity_calc = 32'h80000000;
        clipped_calc  = 1'b1;
      end else begin
        velocity_calc = 32'd0 - mag[31:0];
        clipped_calc  = 1'b0;
      end
    end else begin
      if (mag > 41'h07fffffff) begin
        velocity_calc = 32'h7fffffff;
        clipped_calc  = 1'b1;
      end else begin
        velocity_calc = mag[31:0];
        clipped_calc  = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/gripper_force_deformation_control_top.sv =====
// measurement: the linear model skips the square roots; the root model runs two square
//   roots in turn on the shared root unit; stop runs only the zero-emit step
// throughput: next request taken in the cycle the previous result is loaded; command
//   and start requests give no result and do not hold off the next request
// reset: synchronous, active high; registers to their defaults, not running, target zero
module gripper_force_deformation_control_top import gfdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  // request channel
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         kind,
  input  logic signed [23:0] force_value,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] velocity,
  output logic               clipped
);

  // configuration registers
  logic [23:0] gain;
  logic [22:0] force_limit;
  logic [31:0] linear_compliance;
  logic [31:0] root_coefficient;
  logic        linear_mode;
  logic        run_default;

  // block state
  logic [22:0] target_force;
  logic        running;
  logic [23:0] f_mag;

  logic        cfg_we;
  logic [2:0]  cfg_idx;

  logic        item_acc;
  logic [23:0] force_u;
  logic [23:0] f_abs;
  logic [22:0] f_clamp;
  logic        seq_start;
  step_t       start_step;
  logic        seq_ready;
  logic        out_free;
  ctrl_word_t  ctrl;
  logic        sq_more;
  logic [31:0] velocity_calc;
  logic        clipped_calc;

  // register file: word address, low address bits ignored
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_GAIN:        prdata = {8'd0, gain};
      REG_FORCE_LIMIT: prdata = {9'd0, force_limit};
      REG_LIN_COMPL:   prdata = linear_compliance;
      REG_ROOT_COEF:   prdata = root_coefficient;
      REG_LIN_MODE:    prdata = {31'd0, linear_mode};
      REG_START_RUN:   prdata = {31'd0, run_default};
      default:         prdata = '0;
    endcase
  end

  // request side: the sequencer only blocks while a measurement or stop is in flight
  assign item_stall = ~seq_ready;
  assign item_acc   = item_valid & ~item_stall;

  // magnitude of the signed force; the most negative code maps to 2^23
  assign force_u = force_value;
  assign f_abs   = force_u[23] ? (~force_u + 24'd1) : force_u;
  assign f_clamp = (f_abs > {1'b0, force_limit}) ? force_limit : f_abs[22:0];

  // measurements run the program from the top, stop runs the single zero-emit step
  assign seq_start  = item_acc & ((kind == KIND_STOP) | ((kind == KIND_MEASURE) & running));
  assign start_step = (kind == KIND_STOP) ? STEP_ZERO : STEP_MEAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain              <= GAIN_RST;
      force_limit       <= FORCE_LIMIT_RST;
      linear_compliance <= LIN_COMPL_RST;
      root_coefficient  <= ROOT_COEF_RST;
      linear_mode       <= 1'b0;
      run_default       <= 1'b0;
      running           <= 1'b0;
      target_force      <= '0;
    end else begin
      if (item_acc) begin
        case (kind_t'(kind))
          KIND_STOP:    running <= 1'b0;
          KIND_START:   running <= 1'b1;
          KIND_COMMAND: begin
            if (running) begin
              target_force <= f_clamp;
            end
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_GAIN:        gain              <= pwdata[23:0];
          REG_FORCE_LIMIT: force_limit       <= pwdata[22:0];
          REG_LIN_COMPL:   linear_compliance <= pwdata;
          REG_ROOT_COEF:   root_coefficient  <= pwdata;
          REG_LIN_MODE:    linear_mode       <= pwdata[0];
          REG_START_RUN: begin
            // writing the flag also sets the live running state
            run_default <= pwdata[0];
            running     <= pwdata[0];
          end
          default: ;
        endcase
      end
    end
  end

  // measured force magnitude held for the whole program
  always_ff @(posedge clk) begin
    if (item_acc && (kind == KIND_MEASURE)) begin
      f_mag <= f_abs;
    end
  end

  gfdc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (seq_start),
    .start_step  (start_step),
    .linear_mode (linear_mode),
    .sq_more     (sq_more),
    .out_free    (out_free),
    .ctrl        (ctrl),
    .ready       (seq_ready)
  );

  gfdc_dp u_dp (
    .clk               (clk),
    .ctrl              (ctrl),
    .f_mag             (f_mag),
    .target_force      (target_force),
    .gain              (gain),
    .linear_compliance (linear_compliance),
    .root_coefficient  (root_coefficient),
    .linear_mode       (linear_mode),
    .sq_more           (sq_more),
    .velocity_calc     (velocity_calc),
    .clipped_calc      (clipped_calc)
  );

  // output register; the emitting step waits until it is free or being drained
  assign out_free = ~result_valid | ~result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctrl.emit_calc | ctrl.emit_zero) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit_zero) begin
      velocity <= '0;
      clipped  <= 1'b0;
    end else if (ctrl.emit_calc) begin
      velocity <= velocity_calc;
      clipped  <= clipped_calc;
    end
  end

  // a stop leaves the block stopped unless a run-flag register write lands in the same cycle
  a_stop_clears_running: assert property (@(posedge clk) disable iff (rst)
    (item_acc && (kind == KIND_STOP)) |=> !running)
    else $error("stop request did not clear running");

  // a running measurement holds off the next request while the program runs
  a_meas_busy: assert property (@(posedge clk) disable iff (rst)
    (item_acc && (kind == KIND_MEASURE) && running) |=> item_stall)
    else $error("measurement did not start the sequencer");

  // a saturated result sits exactly on a 32-bit bound
  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && clipped) |->
      ((velocity == 32'sh7fffffff) || (velocity == 32'sh80000000)))
    else $error("clipped result off the saturation bound");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import gfdc_pkg::*;

  // watchdog: slowest legal gap is a root-mode measurement behind a source gap and
  // repeated sink stalls; this is several times that
  localparam int unsigned STUCK_LIMIT = 4000;
  // cycles to let a request with no result finish before touching registers
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned REQS_PER_PHASE = 175;
  // index beyond the register list, writes there must be ignored
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    kind_t       k;
    logic [23:0] f;
  } request_t;

  typedef struct packed {
    logic [31:0] vel;
    logic        clip;
  } velocity_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // request channel
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         kind = KIND_MEASURE;
  logic signed [23:0] force_value = '0;

  // result channel
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] velocity;
  logic               clipped;

  gripper_force_deformation_control_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .force_value  (force_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .velocity     (velocity),
    .clipped      (clipped)
  );

  always #5 clk = ~clk;

  // shadow copy of the registers and the regulator state
  logic [23:0] cfg_gain = GAIN_RST;
  logic [22:0] cfg_limit = FORCE_LIMIT_RST;
  logic [31:0] cfg_compl = LIN_COMPL_RST;
  logic [31:0] cfg_root = ROOT_COEF_RST;
  logic        cfg_lin_mode = 1'b0;
  logic [22:0] tgt_force = '0;
  logic        run_flag = 1'b0;

  request_t  req_pending[$];
  velocity_t velocity_q[$];
  int unsigned reqs_in_flight = 0;
  int unsigned mismatches = 0;

  // idle bursts: one in (idle_odds+1) cycles starts a burst on each side
  bit          idle_on = 1'b1;
  int unsigned idle_odds = 8;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned stuck_cycles = 0;

  wire req_fire = item_valid && !item_stall;
  wire res_fire = result_valid && !result_stall;

  // integer square root, two bits per pass
  function automatic logic [63:0] int_sqrt(input logic [63:0] radicand);
    logic [63:0] rem, root, b;
    rem = radicand;
    root = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // force magnitude (Q8.16) to finger deformation (Q.24 mm)
  function automatic logic [63:0] deformation_of(input logic [63:0] f);
    if (cfg_lin_mode)
      return (f * cfg_compl + 64'h8000) >> 16;
    return int_sqrt((f * cfg_root) << 8);
  endfunction

  // apply one accepted request to the state, queue the velocity it yields
  task automatic predict_velocity(input kind_t k, input logic [23:0] raw);
    logic [63:0] mag, d_meas, d_tgt, err, m;
    logic        neg;
    velocity_t   v;
    mag = raw[23] ? (64'h1000000 - raw) : {40'd0, raw};
    case (k)
      KIND_STOP: begin
        run_flag = 1'b0;
        velocity_q.push_back('{32'd0, 1'b0});
      end
      KIND_START: begin
        run_flag = 1'b1;
      end
      KIND_COMMAND: begin
        if (run_flag) tgt_force = (mag > cfg_limit) ? cfg_limit : mag[22:0];
      end
      default: begin
        if (run_flag) begin
          d_meas = deformation_of(mag);
          d_tgt = deformation_of({41'd0, tgt_force});
          neg = d_meas < d_tgt;
          err = neg ? d_tgt - d_meas : d_meas - d_tgt;
          m = (err * cfg_gain + 64'h800000) >> 24;
          v.clip = 1'b0;
          if (neg) begin
            if (m > 64'h80000000) begin
              m = 64'h80000000;
              v.clip = 1'b1;
            end
            v.vel = -m[31:0];
          end else begin
            if (m > 64'h7FFFFFFF) begin
              m = 64'h7FFFFFFF;
              v.clip = 1'b1;
            end
            v.vel = m[31:0];
          end
          velocity_q.push_back(v);
        end
      end
    endcase
  endtask

  task automatic queue_req(input kind_t k, input logic [23:0] f);
    req_pending.push_back('{k, f});
    reqs_in_flight++;
  endtask

  // setup cycle, then access cycle held until pready
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN:        cfg_gain = val[23:0];
      REG_FORCE_LIMIT: cfg_limit = val[22:0];
      REG_LIN_COMPL:   cfg_compl = val;
      REG_ROOT_COEF:   cfg_root = val;
      REG_LIN_MODE:    cfg_lin_mode = val[0];
      REG_START_RUN:   run_flag = val[0];
      default: ;
    endcase
  endtask

  // all requests taken, all velocities seen, then let the block settle
  task automatic wait_idle();
    while (reqs_in_flight != 0 || velocity_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register value by case: zero, top, reset default, small, full random
  function automatic logic [31:0] pick_value(input logic [31:0] maxv, input logic [31:0] rstv,
                                             input int unsigned sel);
    case (sel % 5)
      0: return 32'd0;
      1: return maxv;
      2: return rstv;
      3: return $urandom_range(0, maxv >> 8);
      default: return $urandom;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (req_fire) begin
        predict_velocity(kind_t'(kind), force_value);
        reqs_in_flight--;
      end
      // payload only changes once the current request is gone
      if (!item_valid || !item_stall) begin
        if (src_gap != 0) begin
          src_gap--;
          item_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
          src_gap = $urandom_range(0, 14);
          item_valid <= 1'b0;
        end else if (req_pending.size() != 0) begin
          nxt = req_pending.pop_front();
          kind <= nxt.k;
          force_value <= nxt.f;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // velocity monitor and sink stalls
  always @(posedge clk) begin
    velocity_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (res_fire) begin
        if (velocity_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected velocity %0d clipped %0b", velocity, clipped);
        end else begin
          want = velocity_q.pop_front();
          if (velocity !== want.vel || clipped !== want.clip) begin
            mismatches++;
            if (mismatches <= 10)
              $display("velocity mismatch: expected %0d clipped %0b, got %0d clipped %0b",
                       $signed(want.vel), want.clip, velocity, clipped);
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, idle_odds) == 0) begin
        sink_gap = $urandom_range(0, 14);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || req_fire || res_fire) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int unsigned issued, sel, p;
    kind_t       k;
    logic [23:0] f, last_cmd;
    bit          gen_run;
    logic [31:0] v;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: root model, not running
    queue_req(KIND_MEASURE, 24'd1000);    // ignored while stopped
    queue_req(KIND_COMMAND, 24'd5000);    // ignored while stopped
    queue_req(KIND_STOP, 24'd0);          // zero velocity even when stopped
    queue_req(KIND_START, 24'hABCDEF);
    queue_req(KIND_MEASURE, 24'd0);
    queue_req(KIND_COMMAND, 24'h7FFFFF);  // clamped to force limit
    queue_req(KIND_MEASURE, 24'd0);
    queue_req(KIND_MEASURE, 24'h800000);
    queue_req(KIND_COMMAND, 24'hF60000);  // negative command, magnitude kept
    queue_req(KIND_MEASURE, 24'h0A0000);
    queue_req(KIND_MEASURE, 24'hFFFFFF);
    queue_req(KIND_MEASURE, 24'd1);
    queue_req(KIND_STOP, 24'h123456);
    wait_idle();

    // linear model at full scale, saturation both ways
    reg_write(REG_GAIN, 32'h00FFFFFF);
    reg_write(REG_FORCE_LIMIT, 32'h007FFFFF);
    reg_write(REG_LIN_COMPL, 32'hFFFFFFFF);
    reg_write(REG_ROOT_COEF, 32'd0);
    reg_write(REG_LIN_MODE, 32'd1);
    reg_write(REG_START_RUN, 32'd1);
    queue_req(KIND_COMMAND, 24'h7FFFFF);
    queue_req(KIND_MEASURE, 24'd0);
    queue_req(KIND_MEASURE, 24'h800000);
    queue_req(KIND_COMMAND, 24'd0);
    queue_req(KIND_MEASURE, 24'h7FFFFF);
    queue_req(KIND_STOP, 24'd0);
    wait_idle();

    // root model at full scale
    reg_write(REG_ROOT_COEF, 32'hFFFFFFFF);
    reg_write(REG_LIN_COMPL, 32'd0);
    reg_write(REG_LIN_MODE, 32'd0);
    reg_write(REG_START_RUN, 32'd1);
    queue_req(KIND_MEASURE, 24'h800000);
    queue_req(KIND_COMMAND, 24'h800000);
    queue_req(KIND_MEASURE, 24'd0);
    queue_req(KIND_STOP, 24'd0);
    wait_idle();

    last_cmd = '0;
    for (p = 0; p < NUM_PHASES; p++) begin
      // quiet handshakes in the closing phase
      idle_on = (p != NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: idle_odds = 3;
        1: idle_odds = 8;
        default: idle_odds = 20;
      endcase
      // offsets walk every register through all value classes
      reg_write(REG_GAIN, pick_value(32'h00FFFFFF, GAIN_RST, p));
      reg_write(REG_FORCE_LIMIT, pick_value(32'h007FFFFF, FORCE_LIMIT_RST, p + 1));
      reg_write(REG_LIN_COMPL, pick_value(32'hFFFFFFFF, LIN_COMPL_RST, p + 2));
      reg_write(REG_ROOT_COEF, pick_value(32'hFFFFFFFF, ROOT_COEF_RST, p + 3));
      reg_write(REG_LIN_MODE, {16'($urandom_range(0, 65535)), 15'd0, p[0]});
      v = $urandom;
      reg_write(REG_START_RUN, v);
      gen_run = v[0];
      if ($urandom_range(0, 2) == 0) reg_write(REG_UNUSED, $urandom);

      issued = 0;
      while (issued < REQS_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (gen_run)
          k = sel < 62 ? KIND_MEASURE : sel < 84 ? KIND_COMMAND : sel < 92 ? KIND_START : KIND_STOP;
        else
          k = sel < 55 ? KIND_START : sel < 75 ? KIND_STOP : sel < 90 ? KIND_MEASURE : KIND_COMMAND;
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
          f = 24'($urandom);
        end else if (sel < 75) begin
          // within the commanded range, either sign
          f = 24'($urandom_range(0, cfg_limit));
          if ($urandom_range(0, 1)) f = -f;
        end else if (sel < 88) begin
          // equal magnitude to the last command gives zero error when that command was taken unclamped
          f = $urandom_range(0, 1) ? last_cmd : -last_cmd;
        end else begin
          case ($urandom_range(0, 4))
            0: f = 24'h000000;
            1: f = 24'h7FFFFF;
            2: f = 24'h800000;
            3: f = 24'hFFFFFF;
            default: f = 24'h000001;
          endcase
        end
        if (k == KIND_COMMAND) last_cmd = f;
        if (gen_run || k == KIND_START || k == KIND_STOP) issued++;
        if (k == KIND_START) gen_run = 1'b1;
        if (k == KIND_STOP) gen_run = 1'b0;
        queue_req(k, f);
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gfdc_pkg.sv
hw/rtl/gfdc_seq.sv
hw/rtl/gfdc_dp.sv
hw/rtl/gripper_force_deformation_control_top.sv
dv/tb_top.sv
